// ===== design/wcpd_pkg.sv =====
// Shared constants and types for the weighted-checksum packet deframer.
// No dependencies; used by wcpd_ctrl, wcpd_dp, the top level and the checker.
package wcpd_pkg;

   // default frame store depth
   localparam int MAX_FRAME_DEF = 32;

   // frame overhead: length byte, sequence byte, checksum byte
   localparam int MIN_OVERHEAD = 3;

   // register port byte address of end_marker
   localparam logic [1:0] REG_END_MARKER = 2'd0;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SHORT    = 3'd1;
   localparam logic [2:0] ST_LENGTH   = 3'd2;
   localparam logic [2:0] ST_CHECKSUM = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic take_byte;   // accept a non-marker byte
      logic clear;       // close frame: count, sum, overflow flag to zero
      logic idx_load;    // start drain at the sequence byte
      logic idx_inc;     // step drain index
      logic mem_rd;      // read frame store at drain index
      logic load_err;    // load an error result into the output register
      logic load_data;   // load a payload result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_marker;   // incoming byte equals the end marker
      logic frame_ok;    // closed frame passes all checks
      logic drain_last;  // drain index is at the final payload byte
      logic out_free;    // output register can take a result this cycle
   } sts_type;

endpackage

// ===== design/wcpd_ctrl.sv =====
// Controller state machine for the deframer.
// Depends on wcpd_pkg (command and status structs).
module wcpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wcpd_pkg::sts_type sts,
   output wcpd_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_RD   = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (sts.is_marker) begin
                  state_in = S_EVAL;
               end else begin
                  cmd.take_byte = 1'b1;
               end
            end
         end
         S_EVAL: begin
            if (sts.frame_ok) begin
               cmd.idx_load = 1'b1;
               state_in     = S_RD;
            end else if (sts.out_free) begin
               cmd.load_err = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.load_data = 1'b1;
               if (sts.drain_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/wcpd_dp.sv =====
// Datapath: frame store memory, count, running checksum, frame checks, output register.
// Depends on wcpd_pkg (codes, command and status structs).
module wcpd_dp #(
   parameter int MAX_FRAME = wcpd_pkg::MAX_FRAME_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_rx_byte,
   input  logic [7:0]        end_marker,
   input  wcpd_pkg::cmd_type cmd,
   output wcpd_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);

   localparam int CNT_W  = $clog2(MAX_FRAME + 1);
   localparam int ADDR_W = $clog2(MAX_FRAME);

   logic [7:0]        mem [MAX_FRAME];
   logic [7:0]        rd_data_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        sum_ff, sum_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        len_ff;
   logic [7:0]        tail_ff;
   logic [CNT_W-1:0]  idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        out_byte_ff;
   logic [2:0]        out_status_ff;
   logic              out_last_ff;

   logic              full;
   logic              store;
   logic [CNT_W-1:0]  count_next;
   logic [15:0]       add_prod;
   logic [15:0]       tail_prod;
   logic [7:0]        net_sum;
   logic [8:0]        want_count;
   logic [2:0]        err_code;

   assign full       = (count_ff == CNT_W'(MAX_FRAME));
   assign store      = cmd.take_byte && !full;
   assign count_next = count_ff + CNT_W'(1);
   assign add_prod   = req_rx_byte * 8'(count_next);

   // take back the checksum byte's own share
   assign tail_prod  = tail_ff * 8'(count_ff);
   assign net_sum    = sum_ff - tail_prod[7:0];
   assign want_count = {1'b0, len_ff} + 9'(wcpd_pkg::MIN_OVERHEAD);

   always_comb begin
      if (ovf_ff) begin
         err_code = wcpd_pkg::ST_OVERFLOW;
      end else if (count_ff <= CNT_W'(wcpd_pkg::MIN_OVERHEAD)) begin
         err_code = wcpd_pkg::ST_SHORT;
      end else if (want_count != 9'(count_ff)) begin
         err_code = wcpd_pkg::ST_LENGTH;
      end else if (net_sum != tail_ff) begin
         err_code = wcpd_pkg::ST_CHECKSUM;
      end else begin
         err_code = wcpd_pkg::ST_OK;
      end
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      if (cmd.clear) begin
         count_in = '0;
         sum_in   = '0;
         ovf_in   = 1'b0;
      end else if (cmd.take_byte) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_next;
            sum_in   = sum_ff + add_prod[7:0];
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_load) begin
         idx_in = CNT_W'(1);
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   assign rsp_valid_in = (cmd.load_err || cmd.load_data) || (rsp_valid_ff && rsp_stall);

   assign sts.is_marker  = (req_rx_byte == end_marker);
   assign sts.frame_ok   = (err_code == wcpd_pkg::ST_OK);
   assign sts.drain_last = (({1'b0, idx_ff} + (CNT_W+1)'(2)) == {1'b0, count_ff});
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   // frame store
   always_ff @(posedge clock) begin
      if (store) begin
         mem[count_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[idx_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // header and tail copies, no reset
   always_ff @(posedge clock) begin
      if (store) begin
         tail_ff <= req_rx_byte;
         if (count_ff == '0) begin
            len_ff <= req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_err) begin
         out_byte_ff   <= '0;
         out_status_ff <= err_code;
         out_last_ff   <= 1'b1;
      end else if (cmd.load_data) begin
         out_byte_ff   <= rd_data_ff;
         out_status_ff <= wcpd_pkg::ST_OK;
         out_last_ff   <= sts.drain_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_last     = out_last_ff;

endmodule

// ===== design/weighted_checksum_packet_deframer.sv =====
// Top level of the weighted-checksum packet deframer: APB register, controller, datapath.
// Depends on wcpd_pkg, wcpd_ctrl and wcpd_dp.
//
// Receives one serial byte per request. Bytes other than end_marker are stored
// in a MAX_FRAME-deep frame store and folded into an 8-bit checksum
// (byte times position, from 1); such bytes are taken back to back. Bytes past
// MAX_FRAME are dropped and mark the frame as overflowed. The end marker closes
// the frame: it is checked (overflow, then too short, then length byte + 3 !=
// count, then checksum), after which a bad frame yields one error result
// (out_byte 0, last 1) and a good frame yields the sequence byte and the
// payload, last set on the final one. Each good result takes a frame store
// read, then the output register load. Requests are stalled from the end
// marker until the last result is loaded. The output register lets new
// requests in while the final result waits. end_marker is written at address
// 0 of the register port and resets to 0.
module weighted_checksum_packet_deframer #(
   parameter int MAX_FRAME = wcpd_pkg::MAX_FRAME_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   wcpd_pkg::cmd_type cmd;
   wcpd_pkg::sts_type sts;

   logic [7:0] end_marker_ff;
   logic [7:0] end_marker_in;
   logic       csr_wr;

   // only the aligned word address 0 writes the register; reads return it at every address
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == wcpd_pkg::REG_END_MARKER);
   assign end_marker_in = csr_wr ? pwdata[7:0] : end_marker_ff;
   assign prdata = {24'd0, end_marker_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         end_marker_ff <= '0;
      end else begin
         end_marker_ff <= end_marker_in;
      end
   end

   wcpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wcpd_dp #(
      .MAX_FRAME (MAX_FRAME)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_rx_byte  (req_rx_byte),
      .end_marker   (end_marker_ff),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== design/wcpd_chk.sv =====
// Port-level checker for the deframer, bound to the top level.
// Depends on wcpd_pkg (status codes) and weighted_checksum_packet_deframer.
module wcpd_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_status,
   input logic       rsp_last
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   // error result is a single, zeroed, final result
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != wcpd_pkg::ST_OK) |-> rsp_last && (rsp_out_byte == 8'd0))
      else $error("malformed error result");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= wcpd_pkg::ST_OVERFLOW)
      else $error("status code out of range");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("requests stalled after reset");

endmodule

bind weighted_checksum_packet_deframer wcpd_chk u_wcpd_chk (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_status   (rsp_status),
   .rsp_last     (rsp_last)
);
